// ----- sv/source_text_lexer_macros.svh -----
// Assertion macros for the source text lexer.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef SOURCE_TEXT_LEXER_MACROS_SVH
`define SOURCE_TEXT_LEXER_MACROS_SVH
`ifndef SYNTHESIS
`define STL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define STL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define STL_ASSERT(lbl, prop, msg)
`define STL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/stl_pkg.sv -----
// Shared types, token kind codes, byte codes and keyword tables of the lexer.
// Depends on nothing.
package stl_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned FIFO_DEPTH        = 4;
  localparam int unsigned NUM_KW            = 7;
  localparam int unsigned KW_MAX            = 7;
  localparam logic [6:0]  HITS_ALL          = 7'h7F;
  localparam logic [15:0] LINE_MAX          = 16'hFFFF;

  localparam logic [4:0] K_IDENT   = 5'd7;
  localparam logic [4:0] K_NUMBER  = 5'd8;
  localparam logic [4:0] K_STRING  = 5'd9;
  localparam logic [4:0] K_ASSIGN  = 5'd10;
  localparam logic [4:0] K_PLUS    = 5'd11;
  localparam logic [4:0] K_MINUS   = 5'd12;
  localparam logic [4:0] K_MUL     = 5'd13;
  localparam logic [4:0] K_DIV     = 5'd14;
  localparam logic [4:0] K_EQ      = 5'd15;
  localparam logic [4:0] K_NE      = 5'd16;
  localparam logic [4:0] K_LT      = 5'd17;
  localparam logic [4:0] K_GT      = 5'd18;
  localparam logic [4:0] K_LE      = 5'd19;
  localparam logic [4:0] K_GE      = 5'd20;
  localparam logic [4:0] K_LPAREN  = 5'd21;
  localparam logic [4:0] K_RPAREN  = 5'd22;
  localparam logic [4:0] K_LBRACE  = 5'd23;
  localparam logic [4:0] K_RBRACE  = 5'd24;
  localparam logic [4:0] K_EOF     = 5'd25;
  localparam logic [4:0] K_BADBYTE = 5'd26;
  localparam logic [4:0] K_UNTERM  = 5'd27;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keyword spellings, one row per keyword kind, padded with zeros.
  localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX] = '{
    '{8'h64, 8'h65, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6D, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6D, 8'h61, 8'h6E, 8'h61, 8'h00, 8'h00, 8'h00},
    '{8'h6D, 8'h67, 8'h62, 8'h65, 8'h00, 8'h00, 8'h00},
    '{8'h67, 8'h6F, 8'h73, 8'h69, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h7A, 8'h69, 8'h6F, 8'h6B, 8'h77, 8'h75},
    '{8'hE1, 8'hBB, 8'hA5, 8'h67, 8'h68, 8'h61, 8'h00}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd2, 3'd4, 3'd4, 3'd4, 3'd7, 3'd6};

  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_IDENT   = 6'b000010,
    M_NUMBER  = 6'b000100,
    M_STRING  = 6'b001000,
    M_OPER    = 6'b010000,
    M_COMMENT = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start_offset;
    logic [15:0] text_length;
    logic [15:0] src_line;
    logic [7:0]  bad_byte;
    logic        last;
  } token_t;

  // One queue entry holds every token that one input beat produced.
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } entry_t;

endpackage

// ----- sv/source_text_lexer.sv -----
// Top level of the streaming source text lexer.
// Depends on stl_pkg, stl_front, stl_fifo and stl_back.
//
//   port group   dir  tdata                                   tuser  tlast
//   s_axis       in   text_byte                               op     -
//   m_axis       out  start, length, line, bad_byte (56 bits) kind   last
//
// The front end takes one source byte per cycle while the queue is not full
// and writes its tokens into a four-entry queue in the same cycle.
// The output stage sends one token per cycle while m_axis is ready; a byte
// that closes one token and yields another sends the two as separate beats.
// s_axis_tready_o drops only while the queue is full, so a stalled output
// blocks the input once four token-producing beats wait in the queue.
// Reset puts the scanner at line 1, offset 0; the end marker does the same.
module source_text_lexer #(
  parameter int unsigned POSITION_BITS = stl_pkg::POSITION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // text_byte
  input  logic        s_axis_tuser_i,  // op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // start_offset, text_length, src_line, bad_byte
  output logic [4:0]  m_axis_tuser_o,  // kind
  output logic        m_axis_tlast_o   // last
);

  logic            push, pop, empty, full;
  stl_pkg::entry_t entry, head;

  stl_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .full_i         (full),
    .push_o         (push),
    .entry_o        (entry)
  );

  stl_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty),
    .full_o (full)
  );

  stl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .empty_i        (empty),
    .pop_o          (pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

// ----- sv/stl_front.sv -----
// Front end of the lexer: accepts source beats, updates the scanner state
// and builds one queue entry per beat that yields tokens. Depends on stl_pkg.
module stl_front #(
  parameter int unsigned POSITION_BITS = stl_pkg::POSITION_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [7:0]      s_axis_tdata_i,  // text_byte
  input  logic            s_axis_tuser_i,  // op
  input  logic            full_i,
  output logic            push_o,
  output stl_pkg::entry_t entry_o
);

  localparam int unsigned P  = POSITION_BITS;
  localparam int unsigned EW = (P > 16) ? P : 17;
  localparam logic [P-1:0] POS_MAX = '1;

  stl_pkg::mode_e mode_q, mode_d;
  logic [7:0]     held_q, held_d;
  logic [P-1:0]   start_q, start_d;
  logic [P-1:0]   len_q, len_d;
  logic [15:0]    line_q, line_d;
  logic [6:0]     hits_q, hits_d;
  logic [P-1:0]   pos_q, pos_d;

  logic           accept;
  logic [7:0]     b;
  logic           is_alpha, is_digit, id_first, id_more;

  stl_pkg::mode_e sb_mode;
  logic [7:0]     sb_held;
  logic [P-1:0]   sb_start, sb_len;
  logic [6:0]     sb_hits;
  logic           sb_line, sb_emit;
  stl_pkg::token_t sb_tok;

  logic           f_en, s_en, do_line;
  stl_pkg::token_t f_tok, s_tok, ident_tok, held_tok, t0, t1;
  logic [4:0]     ident_kind, pair_kind;

  function automatic logic [P-1:0] pos_inc(input logic [P-1:0] v);
    return (v == POS_MAX) ? v : v + P'(1);
  endfunction

  function automatic logic [15:0] clamp16(input logic [P-1:0] v);
    logic [EW-1:0] ext;
    ext = EW'(v);
    return (|ext[EW-1:16]) ? 16'hFFFF : ext[15:0];
  endfunction

  function automatic stl_pkg::token_t make_tok(input logic [4:0] kind,
                                               input logic [P-1:0] start,
                                               input logic [P-1:0] len,
                                               input logic [7:0] bad,
                                               input logic [15:0] line);
    stl_pkg::token_t t;
    t.kind         = kind;
    t.start_offset = clamp16(start);
    t.text_length  = clamp16(len);
    t.src_line     = line;
    t.bad_byte     = bad;
    t.last         = 1'b0;
    return t;
  endfunction

  function automatic logic [6:0] hits_update(input logic [6:0] hits,
                                             input logic [P-1:0] idx,
                                             input logic [7:0] c);
    logic [6:0] h;
    h = '0;
    for (int k = 0; k < stl_pkg::NUM_KW; k++) begin
      if (hits[k] && (idx < P'(stl_pkg::KW_LEN[k])) &&
          (stl_pkg::KW_TEXT[k][idx[2:0]] == c)) begin
        h[k] = 1'b1;
      end
    end
    return h;
  endfunction

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !full_i;
  assign b               = s_axis_tdata_i;

  assign is_alpha = ((b >= stl_pkg::CH_LOWER_A) && (b <= stl_pkg::CH_LOWER_Z)) ||
                    ((b >= stl_pkg::CH_UPPER_A) && (b <= stl_pkg::CH_UPPER_Z));
  assign is_digit = (b >= stl_pkg::CH_0) && (b <= stl_pkg::CH_9);
  assign id_first = is_alpha || (b == stl_pkg::CH_UNDER) || b[7];
  assign id_more  = id_first || is_digit;

  // Start of a new token from the idle state.
  always_comb begin
    sb_mode  = stl_pkg::M_IDLE;
    sb_held  = held_q;
    sb_start = start_q;
    sb_len   = len_q;
    sb_hits  = stl_pkg::HITS_ALL;
    sb_line  = 1'b0;
    sb_emit  = 1'b0;
    sb_tok   = make_tok(stl_pkg::K_BADBYTE, pos_q, P'(1), b, line_q);
    if ((b == stl_pkg::CH_SPACE) || (b == stl_pkg::CH_TAB) || (b == stl_pkg::CH_CR)) begin
      sb_mode = stl_pkg::M_IDLE;
    end else if (b == stl_pkg::CH_LF) begin
      sb_line = 1'b1;
    end else if (id_first) begin
      sb_mode  = stl_pkg::M_IDENT;
      sb_start = pos_q;
      sb_len   = P'(1);
      sb_hits  = hits_update(stl_pkg::HITS_ALL, '0, b);
    end else if (is_digit) begin
      sb_mode  = stl_pkg::M_NUMBER;
      sb_start = pos_q;
      sb_len   = P'(1);
    end else begin
      unique case (b)
        stl_pkg::CH_QUOTE: begin
          sb_mode  = stl_pkg::M_STRING;
          sb_start = pos_inc(pos_q);
          sb_len   = '0;
        end
        stl_pkg::CH_EQ, stl_pkg::CH_LT, stl_pkg::CH_GT, stl_pkg::CH_BANG,
        stl_pkg::CH_SLASH: begin
          sb_mode  = stl_pkg::M_OPER;
          sb_held  = b;
          sb_start = pos_q;
        end
        stl_pkg::CH_PLUS: begin
          sb_emit = 1'b1;
          sb_tok  = make_tok(stl_pkg::K_PLUS, pos_q, P'(1), 8'h00, line_q);
        end
        stl_pkg::CH_MINUS: begin
          sb_emit = 1'b1;
          sb_tok  = make_tok(stl_pkg::K_MINUS, pos_q, P'(1), 8'h00, line_q);
        end
        stl_pkg::CH_STAR: begin
          sb_emit = 1'b1;
          sb_tok  = make_tok(stl_pkg::K_MUL, pos_q, P'(1), 8'h00, line_q);
        end
        stl_pkg::CH_LPAREN: begin
          sb_emit = 1'b1;
          sb_tok  = make_tok(stl_pkg::K_LPAREN, pos_q, P'(1), 8'h00, line_q);
        end
        stl_pkg::CH_RPAREN: begin
          sb_emit = 1'b1;
          sb_tok  = make_tok(stl_pkg::K_RPAREN, pos_q, P'(1), 8'h00, line_q);
        end
        stl_pkg::CH_LBRACE: begin
          sb_emit = 1'b1;
          sb_tok  = make_tok(stl_pkg::K_LBRACE, pos_q, P'(1), 8'h00, line_q);
        end
        stl_pkg::CH_RBRACE: begin
          sb_emit = 1'b1;
          sb_tok  = make_tok(stl_pkg::K_RBRACE, pos_q, P'(1), 8'h00, line_q);
        end
        default: begin
          sb_emit = 1'b1;
        end
      endcase
    end
  end

  // Tokens that close the current identifier or held operator.
  always_comb begin
    ident_kind = stl_pkg::K_IDENT;
    for (int k = 0; k < stl_pkg::NUM_KW; k++) begin
      if (hits_q[k] && (len_q == P'(stl_pkg::KW_LEN[k]))) begin
        ident_kind = 5'(k);
      end
    end
    ident_tok = make_tok(ident_kind, start_q, len_q, 8'h00, line_q);

    unique case (held_q)
      stl_pkg::CH_EQ:    held_tok = make_tok(stl_pkg::K_ASSIGN, start_q, P'(1), 8'h00, line_q);
      stl_pkg::CH_LT:    held_tok = make_tok(stl_pkg::K_LT, start_q, P'(1), 8'h00, line_q);
      stl_pkg::CH_GT:    held_tok = make_tok(stl_pkg::K_GT, start_q, P'(1), 8'h00, line_q);
      stl_pkg::CH_SLASH: held_tok = make_tok(stl_pkg::K_DIV, start_q, P'(1), 8'h00, line_q);
      default:           held_tok = make_tok(stl_pkg::K_BADBYTE, start_q, P'(1), held_q, line_q);
    endcase

    unique case (held_q)
      stl_pkg::CH_EQ: pair_kind = stl_pkg::K_EQ;
      stl_pkg::CH_LT: pair_kind = stl_pkg::K_LE;
      stl_pkg::CH_GT: pair_kind = stl_pkg::K_GE;
      default:        pair_kind = stl_pkg::K_NE;
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    held_d  = held_q;
    start_d = start_q;
    len_d   = len_q;
    hits_d  = hits_q;
    pos_d   = pos_q;
    do_line = 1'b0;
    f_en    = 1'b0;
    f_tok   = ident_tok;
    s_en    = 1'b0;
    s_tok   = sb_tok;

    if (s_axis_tuser_i == stl_pkg::OP_END) begin
      unique case (mode_q)
        stl_pkg::M_IDENT: begin
          f_en = 1'b1;
        end
        stl_pkg::M_NUMBER: begin
          f_en  = 1'b1;
          f_tok = make_tok(stl_pkg::K_NUMBER, start_q, len_q, 8'h00, line_q);
        end
        stl_pkg::M_STRING: begin
          f_en  = 1'b1;
          f_tok = make_tok(stl_pkg::K_UNTERM, start_q, len_q, 8'h00, line_q);
        end
        stl_pkg::M_OPER: begin
          f_en  = 1'b1;
          f_tok = held_tok;
        end
        default: begin
          f_en = 1'b0;
        end
      endcase
      s_en    = 1'b1;
      s_tok   = make_tok(stl_pkg::K_EOF, pos_q, '0, 8'h00, line_q);
      mode_d  = stl_pkg::M_IDLE;
      held_d  = 8'h00;
      start_d = '0;
      len_d   = '0;
      hits_d  = stl_pkg::HITS_ALL;
      pos_d   = '0;
    end else begin
      pos_d = pos_inc(pos_q);
      unique case (mode_q)
        stl_pkg::M_IDENT: begin
          if (id_more) begin
            hits_d = hits_update(hits_q, len_q, b);
            len_d  = pos_inc(len_q);
          end else begin
            f_en    = 1'b1;
            mode_d  = sb_mode;
            held_d  = sb_held;
            start_d = sb_start;
            len_d   = sb_len;
            hits_d  = sb_hits;
            do_line = sb_line;
            s_en    = sb_emit;
          end
        end
        stl_pkg::M_NUMBER: begin
          if (is_digit) begin
            len_d = pos_inc(len_q);
          end else begin
            f_en    = 1'b1;
            f_tok   = make_tok(stl_pkg::K_NUMBER, start_q, len_q, 8'h00, line_q);
            mode_d  = sb_mode;
            held_d  = sb_held;
            start_d = sb_start;
            len_d   = sb_len;
            hits_d  = sb_hits;
            do_line = sb_line;
            s_en    = sb_emit;
          end
        end
        stl_pkg::M_STRING: begin
          if (b == stl_pkg::CH_QUOTE) begin
            f_en   = 1'b1;
            f_tok  = make_tok(stl_pkg::K_STRING, start_q, len_q, 8'h00, line_q);
            mode_d = stl_pkg::M_IDLE;
          end else begin
            do_line = (b == stl_pkg::CH_LF);
            len_d   = pos_inc(len_q);
          end
        end
        stl_pkg::M_OPER: begin
          if ((held_q == stl_pkg::CH_SLASH) && (b == stl_pkg::CH_SLASH)) begin
            mode_d = stl_pkg::M_COMMENT;
            held_d = 8'h00;
          end else if ((b == stl_pkg::CH_EQ) && (held_q != stl_pkg::CH_SLASH)) begin
            f_en   = 1'b1;
            f_tok  = make_tok(pair_kind, start_q, P'(2), 8'h00, line_q);
            mode_d = stl_pkg::M_IDLE;
            held_d = 8'h00;
          end else begin
            f_en    = 1'b1;
            f_tok   = held_tok;
            mode_d  = sb_mode;
            held_d  = (sb_mode == stl_pkg::M_OPER) ? sb_held : 8'h00;
            start_d = sb_start;
            len_d   = sb_len;
            hits_d  = sb_hits;
            do_line = sb_line;
            s_en    = sb_emit;
          end
        end
        stl_pkg::M_COMMENT: begin
          if (b == stl_pkg::CH_LF) begin
            do_line = 1'b1;
            mode_d  = stl_pkg::M_IDLE;
          end
        end
        default: begin
          mode_d  = sb_mode;
          held_d  = sb_held;
          start_d = sb_start;
          len_d   = sb_len;
          hits_d  = sb_hits;
          do_line = sb_line;
          s_en    = sb_emit;
        end
      endcase
    end

    if (s_axis_tuser_i == stl_pkg::OP_END) begin
      line_d = 16'd1;
    end else if (do_line && (line_q != stl_pkg::LINE_MAX)) begin
      line_d = line_q + 16'd1;
    end else begin
      line_d = line_q;
    end
  end

  // The closing token goes first; the last token of the beat carries last.
  always_comb begin
    t0      = f_en ? f_tok : s_tok;
    t0.last = !(f_en && s_en);
    t1      = s_tok;
    t1.last = 1'b1;
    entry_o.two  = f_en && s_en;
    entry_o.tok0 = t0;
    entry_o.tok1 = t1;
  end

  assign push_o = accept && (f_en || s_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stl_pkg::M_IDLE;
      held_q  <= 8'h00;
      start_q <= '0;
      len_q   <= '0;
      line_q  <= 16'd1;
      hits_q  <= stl_pkg::HITS_ALL;
      pos_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      held_q  <= held_d;
      start_q <= start_d;
      len_q   <= len_d;
      line_q  <= line_d;
      hits_q  <= hits_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// ----- sv/stl_fifo.sv -----
// Short token queue between the lexer front end and the output stage.
// Depends on stl_pkg and source_text_lexer_macros.svh.
`include "source_text_lexer_macros.svh"

module stl_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stl_pkg::entry_t entry_i,
  input  logic            pop_i,
  output stl_pkg::entry_t head_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned DEPTH = stl_pkg::FIFO_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  stl_pkg::entry_t mem [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `STL_ASSERT(a_no_overflow, !(push_i && full_o), "token pushed into a full queue")
  `STL_ASSERT(a_no_underflow, !(pop_i && empty_o), "token popped from an empty queue")
  `STL_ASSERT(a_count_tracks, (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CW'(1)), "queue count lost a push")
  `STL_ASSERT_ALWAYS(a_count_range, !rst_ni || (cnt_q <= CW'(DEPTH)), "queue count beyond depth")

endmodule

// ----- sv/stl_back.sv -----
// Output stage: splits two-token queue entries into single beats and holds
// the result register toward the master port. Depends on stl_pkg.
module stl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stl_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [55:0]     m_axis_tdata_o,  // start_offset, text_length, src_line, bad_byte
  output logic [4:0]      m_axis_tuser_o,  // kind
  output logic            m_axis_tlast_o   // last
);

  logic            valid_q, valid_d;
  logic            half_q, half_d;
  logic            load;
  stl_pkg::token_t out_q;

  assign load    = !empty_i && (!valid_q || m_axis_tready_i);
  assign pop_o   = load && (!head_i.two || half_q);
  assign half_d  = load ? (head_i.two && !half_q) : half_q;
  assign valid_d = load ? 1'b1 : (m_axis_tready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= half_q ? head_i.tok1 : head_i.tok0;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {out_q.bad_byte, out_q.src_line, out_q.text_length,
                            out_q.start_offset};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for source_text_lexer: byte streams go in as beats, and the
// token beats that come out are compared with a token predictor held in a scoreboard class.
// Depends on stl_pkg and source_text_lexer.
module tb;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_BEATS   = 1100;
  localparam logic [7:0] LONE_OPS [12] = '{
    stl_pkg::CH_PLUS, stl_pkg::CH_MINUS, stl_pkg::CH_STAR, stl_pkg::CH_LPAREN,
    stl_pkg::CH_RPAREN, stl_pkg::CH_LBRACE, stl_pkg::CH_RBRACE, stl_pkg::CH_EQ,
    stl_pkg::CH_LT, stl_pkg::CH_GT, stl_pkg::CH_SLASH, stl_pkg::CH_BANG};
  localparam logic [7:0] PAIR_HEADS [4] = '{stl_pkg::CH_EQ, stl_pkg::CH_LT, stl_pkg::CH_GT,
                                            stl_pkg::CH_BANG};

  class token_scoreboard;
    stl_pkg::token_t pending_tokens[$];
    stl_pkg::token_t beat_tokens[$];
    int unsigned mismatches;
    int unsigned tokens_seen;
    stl_pkg::mode_e mode;
    logic [7:0] held;
    logic [15:0] tok_start;
    logic [15:0] tok_len;
    logic [15:0] line_no;
    logic [15:0] pos;
    logic [6:0] hits;

    function new();
      restart();
    endfunction

    function void restart();
      mode = stl_pkg::M_IDLE;
      held = '0;
      tok_start = '0;
      tok_len = '0;
      line_no = 16'd1;
      hits = stl_pkg::HITS_ALL;
      pos = '0;
    endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function bit ident_head(logic [7:0] b);
      return (b >= stl_pkg::CH_LOWER_A && b <= stl_pkg::CH_LOWER_Z) ||
             (b >= stl_pkg::CH_UPPER_A && b <= stl_pkg::CH_UPPER_Z) ||
             b == stl_pkg::CH_UNDER || b[7];
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= stl_pkg::CH_0 && b <= stl_pkg::CH_9;
    endfunction

    function void add(logic [4:0] kind, logic [15:0] start, logic [15:0] len, logic [7:0] bad);
      stl_pkg::token_t t;
      t.kind = kind;
      t.start_offset = start;
      t.text_length = len;
      t.src_line = line_no;
      t.bad_byte = bad;
      t.last = 1'b0;
      beat_tokens.push_back(t);
    endfunction

    function logic [6:0] narrow_hits(logic [6:0] h, logic [15:0] idx, logic [7:0] b);
      logic [6:0] r;
      r = '0;
      for (int k = 0; k < stl_pkg::NUM_KW; k++) begin
        if (h[k] && idx < 16'(stl_pkg::KW_LEN[k]) && stl_pkg::KW_TEXT[k][idx[2:0]] == b) begin
          r[k] = 1'b1;
        end
      end
      return r;
    endfunction

    function void close_word();
      logic [4:0] kind;
      kind = stl_pkg::K_IDENT;
      for (int k = 0; k < stl_pkg::NUM_KW; k++) begin
        if (hits[k] && tok_len == 16'(stl_pkg::KW_LEN[k])) kind = 5'(k);
      end
      add(kind, tok_start, tok_len, 8'd0);
      hits = stl_pkg::HITS_ALL;
    endfunction

    function void close_held();
      case (held)
        stl_pkg::CH_EQ: add(stl_pkg::K_ASSIGN, tok_start, 16'd1, 8'd0);
        stl_pkg::CH_LT: add(stl_pkg::K_LT, tok_start, 16'd1, 8'd0);
        stl_pkg::CH_GT: add(stl_pkg::K_GT, tok_start, 16'd1, 8'd0);
        stl_pkg::CH_SLASH: add(stl_pkg::K_DIV, tok_start, 16'd1, 8'd0);
        default: add(stl_pkg::K_BADBYTE, tok_start, 16'd1, held);
      endcase
    endfunction

    function void open_token(logic [7:0] b, logic [15:0] p);
      mode = stl_pkg::M_IDLE;
      if (b == stl_pkg::CH_SPACE || b == stl_pkg::CH_TAB || b == stl_pkg::CH_CR) return;
      if (b == stl_pkg::CH_LF) begin
        line_no = bump(line_no);
        return;
      end
      if (ident_head(b)) begin
        mode = stl_pkg::M_IDENT;
        tok_start = p;
        tok_len = 16'd1;
        hits = narrow_hits(stl_pkg::HITS_ALL, 16'd0, b);
        return;
      end
      if (is_digit(b)) begin
        mode = stl_pkg::M_NUMBER;
        tok_start = p;
        tok_len = 16'd1;
        return;
      end
      case (b)
        stl_pkg::CH_QUOTE: begin
          mode = stl_pkg::M_STRING;
          tok_start = bump(p);
          tok_len = '0;
        end
        stl_pkg::CH_EQ, stl_pkg::CH_LT, stl_pkg::CH_GT, stl_pkg::CH_BANG,
        stl_pkg::CH_SLASH: begin
          mode = stl_pkg::M_OPER;
          held = b;
          tok_start = p;
        end
        stl_pkg::CH_PLUS: add(stl_pkg::K_PLUS, p, 16'd1, 8'd0);
        stl_pkg::CH_MINUS: add(stl_pkg::K_MINUS, p, 16'd1, 8'd0);
        stl_pkg::CH_STAR: add(stl_pkg::K_MUL, p, 16'd1, 8'd0);
        stl_pkg::CH_LPAREN: add(stl_pkg::K_LPAREN, p, 16'd1, 8'd0);
        stl_pkg::CH_RPAREN: add(stl_pkg::K_RPAREN, p, 16'd1, 8'd0);
        stl_pkg::CH_LBRACE: add(stl_pkg::K_LBRACE, p, 16'd1, 8'd0);
        stl_pkg::CH_RBRACE: add(stl_pkg::K_RBRACE, p, 16'd1, 8'd0);
        default: add(stl_pkg::K_BADBYTE, p, 16'd1, b);
      endcase
    endfunction

    function void note_beat(logic op, logic [7:0] b);
      logic [15:0] p;
      logic [4:0] pair;
      stl_pkg::token_t t;
      p = pos;
      beat_tokens.delete();
      if (op == stl_pkg::OP_END) begin
        case (mode)
          stl_pkg::M_IDENT: close_word();
          stl_pkg::M_NUMBER: add(stl_pkg::K_NUMBER, tok_start, tok_len, 8'd0);
          stl_pkg::M_STRING: add(stl_pkg::K_UNTERM, tok_start, tok_len, 8'd0);
          stl_pkg::M_OPER: close_held();
          default: ;
        endcase
        add(stl_pkg::K_EOF, pos, 16'd0, 8'd0);
        restart();
      end else begin
        case (mode)
          stl_pkg::M_IDENT: begin
            if (ident_head(b) || is_digit(b)) begin
              hits = narrow_hits(hits, tok_len, b);
              tok_len = bump(tok_len);
            end else begin
              close_word();
              open_token(b, p);
            end
          end
          stl_pkg::M_NUMBER: begin
            if (is_digit(b)) begin
              tok_len = bump(tok_len);
            end else begin
              add(stl_pkg::K_NUMBER, tok_start, tok_len, 8'd0);
              open_token(b, p);
            end
          end
          stl_pkg::M_STRING: begin
            if (b == stl_pkg::CH_QUOTE) begin
              add(stl_pkg::K_STRING, tok_start, tok_len, 8'd0);
              mode = stl_pkg::M_IDLE;
            end else begin
              if (b == stl_pkg::CH_LF) line_no = bump(line_no);
              tok_len = bump(tok_len);
            end
          end
          stl_pkg::M_OPER: begin
            if (held == stl_pkg::CH_SLASH && b == stl_pkg::CH_SLASH) begin
              mode = stl_pkg::M_COMMENT;
            end else if (b == stl_pkg::CH_EQ && held != stl_pkg::CH_SLASH) begin
              pair = (held == stl_pkg::CH_EQ) ? stl_pkg::K_EQ :
                     (held == stl_pkg::CH_LT) ? stl_pkg::K_LE :
                     (held == stl_pkg::CH_GT) ? stl_pkg::K_GE : stl_pkg::K_NE;
              add(pair, tok_start, 16'd2, 8'd0);
              mode = stl_pkg::M_IDLE;
            end else begin
              close_held();
              open_token(b, p);
            end
            if (mode != stl_pkg::M_OPER) held = '0;
          end
          stl_pkg::M_COMMENT: begin
            if (b == stl_pkg::CH_LF) begin
              line_no = bump(line_no);
              mode = stl_pkg::M_IDLE;
            end
          end
          default: open_token(b, p);
        endcase
        pos = bump(p);
      end
      if (beat_tokens.size() > 0) begin
        t = beat_tokens.pop_back();
        t.last = 1'b1;
        beat_tokens.push_back(t);
      end
      foreach (beat_tokens[i]) pending_tokens.push_back(beat_tokens[i]);
    endfunction

    function int unsigned waiting();
      return pending_tokens.size();
    endfunction

    task report(string msg);
      $display("ERROR at token %0d: %s", tokens_seen, msg);
      mismatches++;
    endtask

    task check_field(string name, int unsigned got_v, int unsigned want_v);
      if (got_v != want_v) report($sformatf("%s is %0d, expected %0d", name, got_v, want_v));
    endtask

    task check_token(stl_pkg::token_t got);
      stl_pkg::token_t want;
      tokens_seen++;
      if (pending_tokens.size() == 0) begin
        report($sformatf("unexpected token of kind %0d", got.kind));
        return;
      end
      want = pending_tokens.pop_front();
      check_field("kind", 32'(got.kind), 32'(want.kind));
      check_field("start_offset", 32'(got.start_offset), 32'(want.start_offset));
      check_field("text_length", 32'(got.text_length), 32'(want.text_length));
      check_field("src_line", 32'(got.src_line), 32'(want.src_line));
      check_field("bad_byte", 32'(got.bad_byte), 32'(want.bad_byte));
      check_field("last", 32'(got.last), 32'(want.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'd0;
  logic        s_axis_tuser_i = stl_pkg::OP_BYTE;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic [4:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  token_scoreboard sb = new();
  logic [7:0] src_text[$];
  bit src_idle_on = 1'b1;
  bit sink_stalls = 1'b1;
  int unsigned src_calm = 0;
  int unsigned sink_calm = 0;
  int unsigned sink_hold = 0;
  int unsigned quiet_cycles = 0;

  source_text_lexer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin : sink_side
    int r;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (!sink_stalls || sink_calm > 0) begin
      m_axis_tready_i <= 1'b1;
      if (sink_calm > 0) sink_calm <= sink_calm - 1;
    end else if (sink_hold > 0) begin
      m_axis_tready_i <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      m_axis_tready_i <= (r < 65);
      if (r < 3) sink_calm <= $urandom_range(20, 60);
      else if (r >= 95) sink_hold <= $urandom_range(8, 30);
      else if (r >= 65) sink_hold <= $urandom_range(0, 2);
    end
  end

  always @(posedge clk_i) begin : observe
    stl_pkg::token_t got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) sb.note_beat(s_axis_tuser_i, s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.kind = m_axis_tuser_o;
        got.start_offset = m_axis_tdata_o[15:0];
        got.text_length = m_axis_tdata_o[31:16];
        got.src_line = m_axis_tdata_o[47:32];
        got.bad_byte = m_axis_tdata_o[55:48];
        got.last = m_axis_tlast_o;
        sb.check_token(got);
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** source_text_lexer: FAILED **");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int r;
    if (!src_idle_on) return 0;
    if (src_calm > 0) begin
      src_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) src_calm = $urandom_range(20, 60);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic send_beat(input logic op, input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic send_source();
    foreach (src_text[i]) send_beat(stl_pkg::OP_BYTE, src_text[i]);
    send_beat(stl_pkg::OP_END, 8'($urandom));
  endtask

  task automatic wait_for_tokens();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.waiting() != 0);
  endtask

  task automatic append_text(string s);
    for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_head();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return stl_pkg::CH_LOWER_A + 8'($urandom_range(0, 25));
    if (r < 8) return stl_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
    if (r == 8) return stl_pkg::CH_UNDER;
    return 8'($urandom_range(128, 255));
  endfunction

  function automatic logic [7:0] rand_digit();
    return stl_pkg::CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_tail();
    return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_head();
  endfunction

  function automatic logic [7:0] rand_inside(logic [7:0] stop);
    logic [7:0] v;
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) v = stl_pkg::CH_LF;
    else if (r == 1) v = 8'($urandom);
    else v = 8'($urandom_range(32, 126));
    if (v == stop) v = stl_pkg::CH_SPACE;
    return v;
  endfunction

  task automatic add_lexeme();
    int r, k, n, cut;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      k = $urandom_range(0, stl_pkg::NUM_KW - 1);
      n = int'(stl_pkg::KW_LEN[k]);
      cut = $urandom_range(0, 7);
      if (cut == 0) n--;
      for (int i = 0; i < n; i++) src_text.push_back(stl_pkg::KW_TEXT[k][i]);
      if (cut == 1) src_text.push_back(rand_tail());
    end else if (r < 30) begin
      src_text.push_back(rand_head());
      repeat ($urandom_range(0, 7)) src_text.push_back(rand_tail());
    end else if (r < 40) begin
      repeat ($urandom_range(1, 5)) src_text.push_back(rand_digit());
    end else if (r < 50) begin
      src_text.push_back(stl_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 8)) src_text.push_back(rand_inside(stl_pkg::CH_QUOTE));
      src_text.push_back(stl_pkg::CH_QUOTE);
    end else if (r < 70) begin
      src_text.push_back(LONE_OPS[$urandom_range(0, 11)]);
    end else if (r < 80) begin
      src_text.push_back(PAIR_HEADS[$urandom_range(0, 3)]);
      src_text.push_back(stl_pkg::CH_EQ);
    end else if (r < 88) begin
      src_text.push_back(stl_pkg::CH_SLASH);
      src_text.push_back(stl_pkg::CH_SLASH);
      repeat ($urandom_range(0, 10)) src_text.push_back(rand_inside(stl_pkg::CH_LF));
      src_text.push_back(stl_pkg::CH_LF);
    end else begin
      src_text.push_back(8'($urandom));
    end
  endtask

  task automatic add_spacing();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) src_text.push_back(stl_pkg::CH_SPACE);
    else if (r < 65) src_text.push_back(stl_pkg::CH_LF);
    else if (r < 70) src_text.push_back(stl_pkg::CH_TAB);
    else if (r < 75) src_text.push_back(stl_pkg::CH_CR);
  endtask

  task automatic compose_program();
    src_text.delete();
    repeat ($urandom_range(1, 20)) begin
      add_lexeme();
      add_spacing();
    end
    if ($urandom_range(0, 9) == 0) begin
      src_text.push_back(stl_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 5)) src_text.push_back(rand_inside(stl_pkg::CH_QUOTE));
    end
  endtask

  initial begin : stimulus
    int unsigned prog_no;
    int unsigned random_beats;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_text.delete();
    append_text("ma!x!=1");
    src_text.push_back(8'h00);
    src_text.push_back(stl_pkg::CH_GT);
    send_source();
    src_text.delete();
    append_text("\"a\n");
    send_source();
    src_text.delete();
    append_text("//");
    src_text.push_back(8'h00);
    src_text.push_back(stl_pkg::CH_LF);
    src_text.push_back(stl_pkg::CH_QUOTE);
    src_text.push_back(8'h00);
    src_text.push_back(stl_pkg::CH_QUOTE);
    src_text.push_back(8'hFF);
    send_source();
    send_beat(stl_pkg::OP_END, 8'hFF);
    wait_for_tokens();

    prog_no = 0;
    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      src_idle_on = (prog_no % 7 != 2);
      sink_stalls = (prog_no % 5 != 3);
      compose_program();
      random_beats += src_text.size() + 1;
      send_source();
      if (prog_no % 10 == 9) wait_for_tokens();
      prog_no++;
    end

    src_idle_on = 1'b1;
    sink_stalls = 1'b1;
    send_beat(stl_pkg::OP_BYTE, stl_pkg::CH_QUOTE);
    repeat (8) send_beat(stl_pkg::OP_BYTE, stl_pkg::CH_LF);
    send_beat(stl_pkg::OP_BYTE, stl_pkg::CH_QUOTE);
    send_beat(stl_pkg::OP_BYTE, stl_pkg::CH_LOWER_A);
    send_beat(stl_pkg::OP_END, 8'h00);

    wait_for_tokens();
    repeat (20) @(posedge clk_i);
    if (sb.waiting() != 0) sb.report($sformatf("%0d tokens never arrived", sb.waiting()));
    if (sb.mismatches == 0) begin
      $display("** source_text_lexer: PASSED **");
    end else begin
      $display("** source_text_lexer: FAILED **");
    end
    $finish;
  end
endmodule
